/* hw/rtl/sst_pkg.sv */
// shared constants and types for the sorted set table
`timescale 1ns / 1ps
package sst_pkg;
	localparam int CAPACITY = 64;
	localparam int KEY_W = 32;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [1:0] OP_TEST = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_cmd_t;
endpackage

/* hw/rtl/sst_cell.sv */
// one entry of the sorted key chain: compare against the request key, shift on update
`timescale 1ns / 1ps
module sst_cell
	import sst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  logic [KEY_W-1:0] key_in,
	input  logic             occupied,
	input  logic [KEY_W-1:0] left_key,
	input  logic             left_lt,
	input  logic [KEY_W-1:0] right_key,
	output logic [KEY_W-1:0] key_q,
	output logic             lt_q,
	output logic             eq_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (cmd.cmp) begin
			lt_q <= occupied && ($signed(key_q) < $signed(key_in));
			eq_q <= occupied && (key_q == key_in);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && !lt_q) begin
			key_q <= left_lt ? key_in : left_key;
		end else if (cmd.del && !lt_q) begin
			key_q <= right_key;
		end
	end
endmodule

/* hw/rtl/sorted_set_table.sv */
// Sorted set of up to CAPACITY distinct signed keys held in a row of compare-and-shift cells.
// A request is captured when it starts; then every cell compares its key with the request
// key, and then the cells shift left or right to delete or insert; the result is strobed on
// done in the cycle after that. busy is high for the compare and shift phases; a new request
// may be started in the cycle that done is high. The result cannot be held off.
`timescale 1ns / 1ps
module sorted_set_table
	import sst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       opcode,
	input  logic [KEY_W-1:0] key,
	output logic             busy,
	output logic             done,
	output logic             success,
	output logic             table_full,
	output logic [6:0]       entry_count
);
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_CMP = 2'd1;
	localparam logic [1:0] PH_UPD = 2'd2;

	logic [1:0]       phase_q;
	logic [1:0]       op_q;
	logic [KEY_W-1:0] req_key_q;
	logic [CNT_W-1:0] count_q;
	logic             done_q;
	logic             success_q;
	logic             full_q;

	cell_cmd_t        cmd;
	logic [KEY_W-1:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0] cell_lt;
	logic [CAPACITY-1:0] cell_eq;
	logic [CAPACITY-1:0] occ;
	logic             found;
	logic             room;
	logic             ins_ok;
	logic             del_ok;

	assign found = |cell_eq;
	assign room = count_q < CNT_W'(CAPACITY);
	assign ins_ok = (phase_q == PH_UPD) && (op_q == OP_INSERT) && !found && room;
	assign del_ok = (phase_q == PH_UPD) && (op_q == OP_DELETE) && found;

	always_comb begin
		cmd.cmp = (phase_q == PH_CMP);
		cmd.ins = ins_ok;
		cmd.del = del_ok;
	end

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic [KEY_W-1:0] lk;
			logic             llt;
			logic [KEY_W-1:0] rk;
			if (i == 0) begin : g_first
				assign lk = req_key_q;
				assign llt = 1'b1;
			end else begin : g_mid
				assign lk = cell_key[i-1];
				assign llt = cell_lt[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign rk = cell_key[i];
			end else begin : g_inner
				assign rk = cell_key[i+1];
			end
			assign occ[i] = count_q > CNT_W'(i);

			sst_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.key_in    (req_key_q),
				.occupied  (occ[i]),
				.left_key  (lk),
				.left_lt   (llt),
				.right_key (rk),
				.key_q     (cell_key[i]),
				.lt_q      (cell_lt[i]),
				.eq_q      (cell_eq[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			done_q <= 1'b0;
			success_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_CMP;
					end
				end
				PH_CMP: begin
					phase_q <= PH_UPD;
				end
				PH_UPD: begin
					phase_q <= PH_IDLE;
					done_q <= 1'b1;
					success_q <= ins_ok || del_ok || ((op_q == OP_TEST) && found);
					full_q <= (op_q == OP_INSERT) && !found && !room;
					if (ins_ok) begin
						count_q <= count_q + CNT_W'(1);
					end else if (del_ok) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= opcode;
			req_key_q <= key;
		end
	end

	assign busy = (phase_q != PH_IDLE);
	assign done = done_q;
	assign success = success_q;
	assign table_full = full_q;
	assign entry_count = 7'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("key count above capacity");

	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_UPD |=> done_q)
		else $error("update phase without done strobe");

	a_count_moves_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> done_q)
		else $error("key count changed outside a result");

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(success_q && full_q))
		else $error("success and full flagged together");
endmodule
